### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
// every check is clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define CHECK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising edge out of reset
`define CHECK_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/lesf_pkg.sv
package lesf_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] EMPTY_RESET  = 8'd46;

    // fixed widths of the result fields
    localparam int SIZE_OUT_W = 11;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_OUT_W  = 16;

    typedef enum logic [1:0] {
        KIND_CELL,
        KIND_NEWLINE,
        KIND_SKIP
    } item_kind_t;

    // control carried from the front end into the cell stage
    typedef struct packed {
        item_kind_t kind;
        logic       is_free;
        logic       up_ok;
        logic       last;
    } cell_ctl_t;

endpackage

### hdl/lesf_row_mem.sv
module lesf_row_mem
    import lesf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/lesf_cell_unit.sv
module lesf_cell_unit
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int ROW_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  cell_ctl_t                         ctl,
    input  logic [$clog2(MAX_COLS)-1:0]       col,
    input  logic [ROW_BITS-1:0]               row,
    input  logic [$clog2(MAX_COLS+1)-1:0]     up_data,
    output logic                              wr_en,
    output logic [$clog2(MAX_COLS+1)-1:0]     wr_data,
    output logic [$clog2(MAX_COLS+1)-1:0]     res_size,
    output logic [$clog2(MAX_COLS)-1:0]       res_col,
    output logic [ROW_BITS-1:0]               res_row,
    output logic                              res_overflow
);

`include "assert_macros.svh"

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int SIZE_W = $clog2(MAX_COLS+1);

    logic [SIZE_W-1:0]   left_size_reg;
    logic [SIZE_W-1:0]   upleft_size_reg;
    logic [SIZE_W-1:0]   max_size_reg;
    logic [ADDR_W-1:0]   max_col_reg;
    logic [ROW_BITS-1:0] max_row_reg;
    logic                overflow_reg;

    logic [SIZE_W-1:0]   max_size_next;
    logic [ADDR_W-1:0]   max_col_next;
    logic [ROW_BITS-1:0] max_row_next;
    logic                overflow_next;

    logic [SIZE_W-1:0]   up;
    logic [SIZE_W-1:0]   lf;
    logic [SIZE_W-1:0]   ul;
    logic [SIZE_W-1:0]   min_ul;
    logic [SIZE_W-1:0]   min_all;
    logic [SIZE_W-1:0]   cur;
    logic                is_cell;
    logic                first_col;

    assign is_cell   = (ctl.kind == KIND_CELL);
    assign first_col = (col == '0);

    // neighbours outside the grid read as zero
    assign up = ctl.up_ok ? up_data : '0;
    assign lf = first_col ? '0 : left_size_reg;
    assign ul = first_col ? '0 : upleft_size_reg;

    assign min_ul  = (up < ul) ? up : ul;
    assign min_all = (lf < min_ul) ? lf : min_ul;
    assign cur     = ctl.is_free ? (min_all + SIZE_W'(1)) : '0;

    always_comb
    begin
        max_size_next = max_size_reg;
        max_col_next  = max_col_reg;
        max_row_next  = max_row_reg;
        overflow_next = overflow_reg | (ctl.kind == KIND_SKIP);
        if (is_cell && (cur > max_size_reg))
        begin
            max_size_next = cur;
            max_col_next  = ADDR_W'(SIZE_W'(col) + SIZE_W'(1) - cur);
            max_row_next  = row + ROW_BITS'(1) - ROW_BITS'(cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_size_reg   <= '0;
            upleft_size_reg <= '0;
            max_size_reg    <= '0;
            max_col_reg     <= '0;
            max_row_reg     <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (ctl.last)
            begin
                left_size_reg   <= '0;
                upleft_size_reg <= '0;
                max_size_reg    <= '0;
                max_col_reg     <= '0;
                max_row_reg     <= '0;
                overflow_reg    <= 1'b0;
            end
            else
            begin
                max_size_reg <= max_size_next;
                max_col_reg  <= max_col_next;
                max_row_reg  <= max_row_next;
                overflow_reg <= overflow_next;
                if (is_cell)
                begin
                    upleft_size_reg <= up;
                    left_size_reg   <= cur;
                end
                else if (ctl.kind == KIND_NEWLINE)
                begin
                    upleft_size_reg <= '0;
                    left_size_reg   <= '0;
                end
            end
        end
    end

    assign wr_en        = fire && is_cell;
    assign wr_data      = cur;
    assign res_size     = max_size_next;
    assign res_col      = max_col_next;
    assign res_row      = max_row_next;
    assign res_overflow = overflow_next;

    `CHECK_PROP(a_max_monotonic, (fire && !ctl.last) |=> (max_size_reg >= $past(max_size_reg)), "best size shrank within a map")
    `CHECK_PROP(a_cur_bounded, (fire && is_cell) |-> ((SIZE_W+1)'(cur) <= (SIZE_W+1)'(col) + (SIZE_W+1)'(1)), "square wider than its column")
    `CHECK_NEVER(a_square_fits, ((SIZE_W+1)'(max_col_reg) + (SIZE_W+1)'(max_size_reg) > (SIZE_W+1)'(MAX_COLS)), "best square runs past the row")

endmodule

### hdl/largest_empty_square_finder.sv
// channel   | direction | tdata fields (lowest bit up)                          | other
// ----------+-----------+-------------------------------------------------------+---------------
// s_axis    | in        | symbol[7:0]                                           | tlast = last
// m_axis    | out       | best_size[10:0] best_col[20:11] best_row[36:21]       | one per map
//           |           | overflow[37], zero pad [39:38]                        |
// cfg       | in        | cfg_data = empty_char[7:0]                            | no index
//
// one map byte per cycle sustained while the cell stage is not held by a waiting result;
// the cell stage's left-neighbour min-plus-one and the registered row memory read set that rate
// m_axis_tvalid rises once the last byte has passed the cell stage register and been loaded
// into the result slot register
// rst_n clears counters, best square, overflow flag and empty_char (to 46); row memory
// contents are not cleared, entries at or past the previous row length read as zero
// a waiting result only stalls the input when a further last byte reaches the cell stage
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int ROW_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // map byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // symbol[7:0]
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // best_size[10:0] best_col[20:11] best_row[36:21]
                                         // overflow[37] zero[39:38]
    // empty character register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

`include "assert_macros.svh"

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int COL_W  = $clog2(MAX_COLS+1);
    localparam int SIZE_W = COL_W;

    // configuration
    logic [7:0] empty_char_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_char_reg <= EMPTY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            empty_char_reg <= cfg_data;
        end
    end

    // front end: row and column counters, advanced as newline and cell bytes are taken
    logic [COL_W-1:0]    col_count_reg;
    logic [COL_W-1:0]    prev_len_reg;
    logic [ROW_BITS-1:0] row_count_reg;

    logic      in_accept;
    item_kind_t in_kind;
    cell_ctl_t  in_ctl;

    // cell stage
    logic                s1_valid_reg;
    cell_ctl_t           s1_ctl_reg;
    logic [ADDR_W-1:0]   s1_col_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic                s1_fire;

    // result register
    logic                 out_valid_reg;
    logic [SIZE_OUT_W-1:0] out_size_reg;
    logic [COL_OUT_W-1:0]  out_col_reg;
    logic [ROW_OUT_W-1:0]  out_row_reg;
    logic                  out_overflow_reg;

    logic [SIZE_W-1:0]   up_data;
    logic                wr_en;
    logic [SIZE_W-1:0]   wr_data;
    logic [SIZE_W-1:0]   res_size;
    logic [ADDR_W-1:0]   res_col;
    logic [ROW_BITS-1:0] res_row;
    logic                res_overflow;

    // the cell stage only holds when it carries a last byte and the result slot is full and not taken
    assign s1_fire       = s1_valid_reg && (!s1_ctl_reg.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_axis_tdata == NEWLINE_BYTE)
        begin
            in_kind = KIND_NEWLINE;
        end
        else if (col_count_reg >= COL_W'(MAX_COLS))
        begin
            in_kind = KIND_SKIP;
        end
        else
        begin
            in_kind = KIND_CELL;
        end
    end

    assign in_ctl.kind    = in_kind;
    assign in_ctl.is_free = (s_axis_tdata == empty_char_reg);
    assign in_ctl.up_ok   = (row_count_reg != '0) && (col_count_reg < prev_len_reg);
    assign in_ctl.last    = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            prev_len_reg  <= '0;
            row_count_reg <= '0;
        end
        else if (in_accept)
        begin
            if (s_axis_tlast)
            begin
                // map finished: start the next one from scratch
                col_count_reg <= '0;
                prev_len_reg  <= '0;
                row_count_reg <= '0;
            end
            else if (in_kind == KIND_NEWLINE)
            begin
                prev_len_reg  <= col_count_reg;
                col_count_reg <= '0;
                row_count_reg <= row_count_reg + ROW_BITS'(1);
            end
            else if (in_kind == KIND_CELL)
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ctl_reg <= in_ctl;
            s1_col_reg <= col_count_reg[ADDR_W-1:0];
            s1_row_reg <= row_count_reg;
        end
    end

    // the read for a column is issued as its byte is taken, the write as it leaves the cell
    // stage; in a map a write and a read of one column always have a newline between them,
    // so they never meet in one cycle and no bypass is needed (a new map's first row ignores the read)
    lesf_row_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (SIZE_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (in_accept && (in_kind == KIND_CELL)),
        .rd_addr (col_count_reg[ADDR_W-1:0]),
        .rd_data (up_data),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    lesf_cell_unit #(
        .MAX_COLS (MAX_COLS),
        .ROW_BITS (ROW_BITS)
    ) u_cell_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s1_fire),
        .ctl          (s1_ctl_reg),
        .col          (s1_col_reg),
        .row          (s1_row_reg),
        .up_data      (up_data),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .res_size     (res_size),
        .res_col      (res_col),
        .res_row      (res_row),
        .res_overflow (res_overflow)
    );

    // result slot, loaded when a last byte leaves the cell stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_ctl_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctl_reg.last)
        begin
            out_size_reg     <= SIZE_OUT_W'(res_size);
            out_col_reg      <= COL_OUT_W'(res_col);
            out_row_reg      <= ROW_OUT_W'(res_row);
            out_overflow_reg <= res_overflow;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_overflow_reg, out_row_reg, out_col_reg, out_size_reg};

    `CHECK_PROP(a_stall_holds, (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_col_reg)), "cell stage lost a held transaction")
    `CHECK_PROP(a_result_source, $rose(m_axis_tvalid) |-> $past(s1_fire && s1_ctl_reg.last), "result appeared without a last transaction")
    `CHECK_NEVER(a_col_saturates, (col_count_reg > COL_W'(MAX_COLS)), "column counter ran past the row limit")

endmodule

### bench/tb_largest_empty_square_finder.sv
module tb_largest_empty_square_finder;
    import lesf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_COLS       = 1024;
    localparam int MAP_ROW_BITS   = 16;
    localparam int unsigned ROW_MASK = (1 << MAP_ROW_BITS) - 1;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off under pressure
    localparam int DRAIN_CYCLES   = 8;       // result is offered once the last byte leaves the cell stage
    localparam int WATCHDOG_LIMIT = 5000;    // cycles without any transaction
    localparam int PHASE_ITEMS    = 35;      // minimum random bytes per empty_char setting
    localparam int MIN_MAPS       = 2;

    // one expected report, field order as on the result stream
    typedef struct packed {
        logic [SIZE_OUT_W-1:0] size;
        logic [COL_OUT_W-1:0]  col;
        logic [ROW_OUT_W-1:0]  row;
        logic                  ovf;
    } square_report_t;

    // tracks the maximal square of the map being streamed and queues reports
    class square_tracker;
        logic [7:0]     empty_char;
        int unsigned    prev_sizes [MAP_COLS];
        int unsigned    prev_len;
        int unsigned    left_sz;
        int unsigned    upleft_sz;
        int unsigned    col_cnt;
        int unsigned    row_cnt;
        int unsigned    best_sz;
        int unsigned    best_c;
        int unsigned    best_r;
        bit             ovf_seen;
        square_report_t due_reports [$];
        int             errors;

        function new();
            empty_char = EMPTY_RESET;
            errors     = 0;
            clear_map();
        endfunction

        function void clear_map();
            foreach (prev_sizes[i])
                prev_sizes[i] = 0;
            prev_len  = 0;
            left_sz   = 0;
            upleft_sz = 0;
            col_cnt   = 0;
            row_cnt   = 0;
            best_sz   = 0;
            best_c    = 0;
            best_r    = 0;
            ovf_seen  = 0;
        endfunction

        // one accepted map byte
        function void take_byte(logic [7:0] sym, logic last);
            int unsigned    c;
            int unsigned    up;
            int unsigned    ul;
            int unsigned    lf;
            int unsigned    cur;
            int unsigned    m;
            square_report_t rpt;
            if (sym == NEWLINE_BYTE)
            begin
                prev_len  = col_cnt;
                col_cnt   = 0;
                left_sz   = 0;
                upleft_sz = 0;
                row_cnt   = (row_cnt + 1) & ROW_MASK;
            end
            else if (col_cnt >= MAP_COLS)
            begin
                // cell past the row store is dropped
                ovf_seen = 1;
            end
            else
            begin
                c   = col_cnt;
                up  = (row_cnt != 0 && c < prev_len) ? prev_sizes[c] : 0;
                ul  = (c != 0) ? upleft_sz : 0;
                lf  = (c != 0) ? left_sz : 0;
                cur = 0;
                if (sym == empty_char)
                begin
                    m   = (up < ul) ? up : ul;
                    m   = (lf < m) ? lf : m;
                    cur = m + 1;
                end
                // strict compare keeps the first largest square in row-major order
                if (cur > best_sz)
                begin
                    best_sz = cur;
                    best_c  = c + 1 - cur;
                    best_r  = (row_cnt + 1 - cur) & ROW_MASK;
                end
                upleft_sz     = up;
                left_sz       = cur;
                prev_sizes[c] = cur;
                col_cnt       = c + 1;
            end
            if (last)
            begin
                rpt.size = best_sz[SIZE_OUT_W-1:0];
                rpt.col  = best_c[COL_OUT_W-1:0];
                rpt.row  = best_r[ROW_OUT_W-1:0];
                rpt.ovf  = ovf_seen;
                due_reports.push_back(rpt);
                clear_map();
            end
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // one accepted result transaction
        function void check_report(logic [39:0] data);
            square_report_t want;
            if (due_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            check_field("best_size", want.size, data[10:0]);
            check_field("best_col",  want.col,  data[20:11]);
            check_field("best_row",  want.row,  data[36:21]);
            check_field("overflow",  want.ovf,  data[37]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // symbol[7:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;      // best_size[10:0] best_col[20:11] best_row[36:21]
                                    // overflow[37] zero[39:38]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    square_tracker sb;
    bit            quiet;           // both sides run without gaps while set
    bit            hold_req;        // asks the receiver for one long hold-off
    int            stall_cycles;

    largest_empty_square_finder #(
        .MAX_COLS (MAP_COLS),
        .ROW_BITS (MAP_ROW_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("tb_largest_empty_square_finder NOT OK");
                $finish;
            end
        end
    end

    // result side: random gaps, one long hold-off on request
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_report(m_axis_tdata);
        end
    end

    // one map byte, held until the block takes it; valid stays high for a back-to-back byte
    task automatic send_byte(input logic [7:0] sym, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = sym;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_byte(sym, last);
    endtask

    task automatic send_seq(input logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] seq [$];
        for (int i = 0; i < s.len(); i++)
            seq.push_back(s[i]);
        send_seq(seq);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // register write only once every report is in and the pipe has drained
    task automatic write_empty_char(input logic [7:0] value);
        stop_sending();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.empty_char = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] obstacle_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sb.empty_char || b == NEWLINE_BYTE);
        return b;
    endfunction

    // mostly well-formed maps (some ragged), now and then pure byte noise
    task automatic send_random_map(output int n);
        logic [7:0] seq [$];
        logic [7:0] b;
        int         mode;
        int         h;
        int         w;
        int         width;
        int         pfree;
        mode = $urandom_range(0, 9);
        h    = $urandom_range(1, 8);
        w    = $urandom_range(1, 10);
        case ($urandom_range(0, 2))
            0:       pfree = 50;
            1:       pfree = 85;
            default: pfree = 97;
        endcase
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 40))
            begin
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 5) == 0)
                    b = NEWLINE_BYTE;
                seq.push_back(b);
            end
        end
        else
        begin
            for (int r = 0; r < h; r++)
            begin
                width = (mode == 1) ? $urandom_range(0, w + 2) : w;
                repeat (width)
                    seq.push_back(($urandom_range(1, 100) <= pfree) ? sb.empty_char
                                                                    : obstacle_byte());
                // the map sometimes ends on its newline
                if (r < h - 1 || $urandom_range(0, 3) == 0)
                    seq.push_back(NEWLINE_BYTE);
            end
        end
        if (seq.size() == 0)
            seq.push_back(NEWLINE_BYTE);
        quiet = ($urandom_range(0, 7) == 0);
        send_seq(seq);
        quiet = 1'b0;
        n = seq.size();
    endtask

    initial
    begin
        logic [7:0] settings [6];
        logic [7:0] seq [$];
        int         n;
        int         phase_bytes;
        int         random_maps;

        sb            = new();
        quiet         = 1'b0;
        hold_req      = 1'b0;
        stall_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed maps at the reset value of empty_char
        send_text("#");                     // no free cell at all
        send_byte(8'h00, 1'b0);             // extreme obstacle bytes
        send_byte(8'hFF, 1'b1);
        send_text(".\n");                   // newline as the last byte
        send_text("..\n.\n..");             // ragged rows
        send_text("\n..");                  // empty first row
        send_text(".#.\n...\n...");         // best square touching the first column

        // over-long row: only the last stored column is free, rest is dropped and flagged
        repeat (MAP_COLS - 1) seq.push_back("#");
        repeat (7) seq.push_back(".");
        seq.push_back(NEWLINE_BYTE);
        seq.push_back(".");
        seq.push_back(".");
        send_seq(seq);

        // fill the block while the result side holds off
        stop_sending();
        while (sb.pending() != 0)
            @(posedge clk);
        quiet    = 1'b1;
        hold_req = 1'b1;
        repeat (6) send_text(".\n.");
        quiet = 1'b0;

        // random maps under several empty_char settings, extremes included
        settings[0] = 8'd0;
        settings[1] = 8'd255;
        settings[2] = NEWLINE_BYTE;
        settings[3] = 8'($urandom_range(0, 255));
        settings[4] = 8'($urandom_range(0, 255));
        settings[5] = EMPTY_RESET;
        random_maps = 0;
        foreach (settings[i])
        begin
            write_empty_char(settings[i]);
            phase_bytes = 0;
            while (phase_bytes < PHASE_ITEMS || (i == 5 && random_maps < MIN_MAPS))
            begin
                send_random_map(n);
                phase_bytes += n;
                random_maps++;
            end
        end

        stop_sending();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_largest_empty_square_finder OK");
        else
            $display("tb_largest_empty_square_finder NOT OK");
        $finish;
    end

endmodule
